// ----- hw/rtl/tpp_pkg.sv -----
// ============================================================================
// tpp_pkg
// Shared types and constants for the PAT / PMT section parser.
// ============================================================================
package tpp_pkg;

    // Default depth of the stream table
    localparam int MAX_STREAMS_DEF = 16;

    // Position arithmetic
    localparam int POS_W = 13;
    localparam logic [POS_W-1:0] POS_MAX = 13'h1FFF;

    // Byte positions of header fields and of the first entries
    localparam logic [POS_W-1:0] POS_SEC_LEN     = 13'd2;
    localparam logic [POS_W-1:0] POS_PROG_NUM    = 13'd4;
    localparam logic [POS_W-1:0] POS_PAT_LOOP    = 13'd7;
    localparam logic [POS_W-1:0] POS_PCR_PID     = 13'd9;
    localparam logic [POS_W-1:0] POS_PROG_INFO   = 13'd11;
    localparam logic [POS_W-1:0] PAT_FIRST_ENTRY = 13'd8;
    localparam logic [POS_W-1:0] PMT_FIRST_ENTRY = 13'd12;

    // Table selector
    localparam logic CMD_PAT = 1'b0;
    localparam logic CMD_PMT = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_NET_PID     = 2'd0;
    localparam logic [1:0] KIND_MAP_PID     = 2'd1;
    localparam logic [1:0] KIND_STREAM_STOR = 2'd2;
    localparam logic [1:0] KIND_STREAM_DROP = 2'd3;

    // Input item
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       section_start;
    } sec_item_t;

    // Result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] prog_num;
        logic [12:0] pid;
        logic [7:0]  strm_type;
        logic [11:0] desc_len;
        logic [3:0]  entry_index;
        logic [12:0] pcr_pid;
    } res_item_t;

endpackage

// ----- hw/rtl/tpp_field_parser.sv -----
// ============================================================================
// tpp_field_parser
// Section state and the per-byte decode of PAT and PMT entries.
// ============================================================================
module tpp_field_parser
    import tpp_pkg::*;
#(
    parameter int MAX_STREAMS = MAX_STREAMS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  sec_item_t item,
    output logic      res_fire,
    output res_item_t res
);

    localparam int CNT_W = $clog2(MAX_STREAMS + 1);
    localparam int SH_W  = 25;
    localparam int EXT_W = POS_W + 1;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [11:0]      slen_reg,  slen_next;
    logic [POS_W-1:0] estart_reg, estart_next;
    logic [SH_W-1:0]  shift_reg, shift_next;
    logic [15:0]      prog_reg,  prog_next;
    logic [12:0]      pcr_reg,   pcr_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;

    logic [POS_W-1:0] p;
    logic [POS_W-1:0] es0;
    logic [EXT_W-1:0] es_ext;
    logic [EXT_W-1:0] p_ext;
    logic [EXT_W-1:0] es_sum;
    logic [11:0]      eil;
    logic [7:0]       b;

    // Per-byte decode
    always_comb
    begin
        b           = item.data_byte;
        p           = item.section_start ? '0 : pos_reg;
        p_ext       = {1'b0, p};
        es0         = item.section_start ? '0 : estart_reg;
        cnt_next    = item.section_start ? '0 : cnt_reg;
        slen_next   = item.section_start ? '0 : slen_reg;
        prog_next   = prog_reg;
        pcr_next    = pcr_reg;
        shift_next  = {shift_reg[SH_W-9:0], b};
        estart_next = es0;
        es_ext      = '0;
        es_sum      = '0;
        eil         = {shift_reg[3:0], b};
        res_fire    = 1'b0;
        res         = '0;

        if (p == POS_SEC_LEN)
            slen_next = {shift_reg[3:0], b};

        if (item.command == CMD_PAT)
        begin
            if (p == POS_PAT_LOOP)
                estart_next = PAT_FIRST_ENTRY;
            es_ext = {1'b0, estart_next};
            if (estart_next >= PAT_FIRST_ENTRY && p_ext == es_ext + EXT_W'(3) &&
                es_ext + EXT_W'(5) <= EXT_W'(slen_next))
            begin
                res_fire     = 1'b1;
                res.prog_num = shift_reg[23:8];
                res.pid      = {shift_reg[4:0], b};
                res.kind = (shift_reg[23:8] == 16'd0) ? KIND_NET_PID : KIND_MAP_PID;
                es_sum      = es_ext + EXT_W'(4);
                estart_next = (es_sum > EXT_W'(POS_MAX)) ? POS_MAX : es_sum[POS_W-1:0];
            end
        end
        else
        begin
            if (p == POS_PROG_NUM)
                prog_next = {shift_reg[7:0], b};
            if (p == POS_PCR_PID)
                pcr_next = {shift_reg[4:0], b};
            if (p == POS_PROG_INFO)
                estart_next = PMT_FIRST_ENTRY + POS_W'({shift_reg[3:0], b});
            es_ext = {1'b0, estart_next};
            if (estart_next >= PMT_FIRST_ENTRY &&
                es_ext + EXT_W'(2) <= EXT_W'(slen_next))
            begin
                if (p_ext == es_ext + EXT_W'(2))
                begin
                    // pack stream type and PID
                    shift_next = SH_W'({shift_reg[15:8], shift_reg[4:0], b});
                end
                else if (p_ext == es_ext + EXT_W'(3))
                begin
                    shift_next = {shift_reg[SH_W-5:0], b[3:0]};
                end
                else if (p_ext == es_ext + EXT_W'(4))
                begin
                    res_fire      = 1'b1;
                    res.prog_num  = prog_next;
                    res.pid       = shift_reg[16:4];
                    res.strm_type = shift_reg[24:17];
                    res.desc_len  = eil;
                    res.pcr_pid   = pcr_next;
                    if (cnt_next < CNT_W'(MAX_STREAMS))
                    begin
                        res.kind        = KIND_STREAM_STOR;
                        res.entry_index = 4'(cnt_next);
                        cnt_next        = cnt_next + CNT_W'(1);
                    end
                    else
                    begin
                        res.kind = KIND_STREAM_DROP;
                    end
                    es_sum      = es_ext + EXT_W'(5) + EXT_W'(eil);
                    estart_next = (es_sum > EXT_W'(POS_MAX)) ? POS_MAX : es_sum[POS_W-1:0];
                end
            end
        end

        pos_next = (p < POS_MAX) ? p + POS_W'(1) : p;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            slen_reg   <= '0;
            estart_reg <= '0;
            shift_reg  <= '0;
            prog_reg   <= '0;
            pcr_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            slen_reg   <= slen_next;
            estart_reg <= estart_next;
            shift_reg  <= shift_next;
            prog_reg   <= prog_next;
            pcr_reg    <= pcr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/tpp_out_buffer.sv -----
// ============================================================================
// tpp_out_buffer
// Result register with a skid stage behind it.
// ============================================================================
module tpp_out_buffer
    import tpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_item_t push_item,
    output logic      full,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    logic      main_vld_reg;
    logic      skid_vld_reg;
    res_item_t main_reg;
    res_item_t skid_reg;
    logic      pop;

    assign pop       = main_vld_reg && !res_stall;
    assign full      = skid_vld_reg;
    assign res_valid = main_vld_reg;
    assign res_item  = main_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (pop)
                skid_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_vld_reg && !pop)
                skid_vld_reg <= 1'b1;
            else
                main_vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_vld_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_vld_reg && !pop)
                skid_reg <= push_item;
            else
                main_reg <= push_item;
        end
    end

endmodule

// ----- hw/rtl/ts_pat_pmt_section_parser.sv -----
// ============================================================================
// ts_pat_pmt_section_parser
// PAT / PMT section parser: one section byte in, at most one entry out.
// ============================================================================
//  channel | direction | handshake            | payload
//  sec     | in        | sec_valid, sec_stall | sec_item (sec_item_t)
//  res     | out       | res_valid, res_stall | res_item (res_item_t)
//
// One byte per cycle sustained while sec_stall is low.
// The input register feeds the decode, which updates section state and
// loads the result register in the same cycle.
// Reset clears all section state and empties both registers.
// A stalled result goes to a skid stage; sec_stall rises only when it is full.
module ts_pat_pmt_section_parser
    import tpp_pkg::*;
#(
    parameter int MAX_STREAMS = MAX_STREAMS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sec_valid,
    output logic      sec_stall,
    input  sec_item_t sec_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    logic      in_vld_reg;
    sec_item_t in_reg;
    logic      buf_full;
    logic      advance;
    logic      fire;
    res_item_t res_next;

    assign advance   = in_vld_reg && !buf_full;
    assign sec_stall = in_vld_reg && buf_full;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (sec_valid && !sec_stall)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sec_valid && !sec_stall)
            in_reg <= sec_item;
    end

    tpp_field_parser #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (in_reg),
        .res_fire (fire),
        .res      (res_next)
    );

    tpp_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && fire),
        .push_item (res_next),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
